// ===== hdl/obe_pkg.sv =====
// ----------------------------------------------------------------------------
// obe_pkg
// Shared types, constants and helper functions for the order book level
// engine: field widths, event codes, level write bundle and bit searches.
// ----------------------------------------------------------------------------
package obe_pkg;

  localparam int TICK_COUNT  = 100;
  localparam int LEVEL_DEPTH = 128;
  localparam int IDX_W       = 7;
  localparam int SIZE_W      = 31;
  localparam int QTY_W       = 32;
  localparam int SEQ_W       = 32;

  localparam logic [SIZE_W-1:0] SIZE_MAX = {SIZE_W{1'b1}};

  // stream word widths
  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 80;

  // output word bit positions
  localparam int OUT_BID_LSB   = 0;
  localparam int OUT_ASK_LSB   = 7;
  localparam int OUT_BSZ_LSB   = 14;
  localparam int OUT_ASZ_LSB   = 45;
  localparam int OUT_VALID_BIT = 76;
  localparam int OUT_READY_BIT = 77;
  localparam int OUT_RESYNC_BIT = 78;

  typedef enum logic [1:0] {
    FUNC_CLEAR      = 2'd0,
    FUNC_SNAP_BEGIN = 2'd1,
    FUNC_SNAP_LEVEL = 2'd2,
    FUNC_DELTA      = 2'd3
  } func_t;

  // one level update for a side: set writes size and marks present,
  // otherwise the level is removed
  typedef struct packed {
    logic              en;
    logic              set;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] size;
  } lvl_wr_t;

  // isolate the lowest set bit
  function automatic logic [LEVEL_DEPTH-1:0] lowest_onehot(
    input logic [LEVEL_DEPTH-1:0] v
  );
    return v & (~v + LEVEL_DEPTH'(1));
  endfunction

  function automatic logic [LEVEL_DEPTH-1:0] bit_reverse(
    input logic [LEVEL_DEPTH-1:0] v
  );
    logic [LEVEL_DEPTH-1:0] r;
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      r[i] = v[LEVEL_DEPTH-1-i];
    end
    return r;
  endfunction

  function automatic logic [LEVEL_DEPTH-1:0] highest_onehot(
    input logic [LEVEL_DEPTH-1:0] v
  );
    return bit_reverse(lowest_onehot(bit_reverse(v)));
  endfunction

  // encode a one-hot vector; each index bit is an OR over its positions
  function automatic logic [IDX_W-1:0] onehot_index(
    input logic [LEVEL_DEPTH-1:0] oh
  );
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < LEVEL_DEPTH; i++) begin
      if (oh[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/obe_level_store.sv =====
// ----------------------------------------------------------------------------
// obe_level_store
// One side of the book: level size memory with one write and two registered
// read ports, plus the per-tick presence map that reset and wipes clear.
// ----------------------------------------------------------------------------
module obe_level_store (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  logic                                  clear,
  input  obe_pkg::lvl_wr_t                      wr,
  input  logic [obe_pkg::IDX_W-1:0]             rd_a_idx,
  output logic [obe_pkg::SIZE_W-1:0]            rd_a_data,
  input  logic [obe_pkg::IDX_W-1:0]             rd_b_idx,
  output logic [obe_pkg::SIZE_W-1:0]            rd_b_data,
  output logic [obe_pkg::LEVEL_DEPTH-1:0]       present
);

  logic [obe_pkg::SIZE_W-1:0]      size_mem [obe_pkg::LEVEL_DEPTH];
  logic [obe_pkg::LEVEL_DEPTH-1:0] present_r;
  logic [obe_pkg::SIZE_W-1:0]      rd_a_r;
  logic [obe_pkg::SIZE_W-1:0]      rd_b_r;

  // reads return the contents from before a write on the same edge
  always_ff @(posedge clk) begin
    if (wr.en && wr.set) begin
      size_mem[wr.idx] <= wr.size;
    end
    if (adv) begin
      rd_a_r <= size_mem[rd_a_idx];
      rd_b_r <= size_mem[rd_b_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
    end else if (clear) begin
      present_r <= '0;
    end else if (wr.en) begin
      present_r[wr.idx] <= wr.set;
    end
  end

  assign rd_a_data = rd_a_r;
  assign rd_b_data = rd_b_r;
  assign present   = present_r;

endmodule

// ===== hdl/order_book_level_engine.sv =====
// An accepted word passes the stage 1, stage 2 and result registers in order.
// Throughput: one word per cycle; a waiting result with out_tready low stalls
// every stage and drops in_tready in the same cycle.
// Reset (rst_n low, synchronous) clears presence maps, sequence state and all
// valid flags at once; level sizes are left as they are and only read where
// their presence bit is set.
// ----------------------------------------------------------------------------
// order_book_level_engine
// Two-sided price-level book: applies clear, snapshot and sequenced delta
// events and reports top of book after every event.
// ----------------------------------------------------------------------------
module order_book_level_engine (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tuser: func[1:0], side[2]
  input  logic [obe_pkg::IN_TUSER_W-1:0]     in_tuser,
  // in_tdata: price[6:0], quantity[38:7], seq[70:39], zero pad
  input  logic [obe_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // out_tdata: top_bid[6:0], top_ask[13:7], top_bid_qty[44:14],
  //            top_ask_qty[75:45], book_valid[76], ready_res[77], resync[78], pad
  output logic [obe_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready
);

  localparam int IW = obe_pkg::IDX_W;
  localparam int SW = obe_pkg::SIZE_W;
  localparam int QW = obe_pkg::QTY_W;
  localparam logic [IW-1:0] TICK_IDX = IW'(obe_pkg::TICK_COUNT);

  logic adv;

  // stage 1: event register
  logic                      s1_v_r;
  obe_pkg::func_t            s1_func_r;
  logic                      s1_side_r;
  logic [IW-1:0]             s1_price_r;
  logic [QW-1:0]             s1_qty_r;
  logic [obe_pkg::SEQ_W-1:0] s1_seq_r;

  // write forwarded from the event just retired
  logic          fwd_v_r;
  logic          fwd_side_r;
  logic [IW-1:0] fwd_idx_r;
  logic [SW-1:0] fwd_size_r;

  // sequence state
  logic [obe_pkg::SEQ_W-1:0] last_seq_r, last_seq_nxt;
  logic                      seq_known_r, seq_known_nxt;
  logic                      book_ready_r, book_ready_nxt;

  // stage 2: book updated, search pending
  logic s2_v_r;
  logic s2_resync_r;
  logic s2_ready_r;

  // result register
  logic          out_v_r;
  logic [IW-1:0] out_bid_r, out_ask_r;
  logic          out_have_bid_r, out_have_ask_r;
  logic          out_valid_r, out_ready_r, out_resync_r;

  obe_pkg::lvl_wr_t wr, wr_bid, wr_ask;
  logic act, wipe, resync_nxt;

  logic [SW-1:0] bid_rd_a, ask_rd_a, bid_rd_b, ask_rd_b;
  logic [obe_pkg::LEVEL_DEPTH-1:0] bid_present, ask_present;

  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv;
  assign act       = s1_v_r && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_func_r  <= obe_pkg::func_t'(in_tuser[1:0]);
      s1_side_r  <= in_tuser[2];
      s1_price_r <= in_tdata[6:0];
      s1_qty_r   <= in_tdata[38:7];
      s1_seq_r   <= in_tdata[70:39];
    end
  end

  // ---- stage 1: apply the event ----
  logic          old_present, fwd_hit, price_ok, seq_ok;
  logic [SW-1:0] old_rd, old_size;
  logic [SW+1:0] sum;
  logic [SW-1:0] delta_size;

  always_comb begin
    old_present = s1_side_r ? ask_present[s1_price_r] : bid_present[s1_price_r];
    old_rd      = s1_side_r ? ask_rd_a : bid_rd_a;
    fwd_hit     = fwd_v_r && (fwd_side_r == s1_side_r) && (fwd_idx_r == s1_price_r);
    old_size    = !old_present ? '0 : (fwd_hit ? fwd_size_r : old_rd);
    sum         = {2'b00, old_size} + {s1_qty_r[QW-1], s1_qty_r};
    // sum is non-negative here; bit SW set means it passed the size range
    delta_size  = sum[SW] ? obe_pkg::SIZE_MAX : sum[SW-1:0];
    price_ok    = s1_price_r <= TICK_IDX;
    seq_ok      = seq_known_r && (s1_seq_r == last_seq_r + 32'd1);
  end

  always_comb begin
    wipe           = 1'b0;
    resync_nxt     = 1'b0;
    wr             = '0;
    wr.idx         = s1_price_r;
    last_seq_nxt   = last_seq_r;
    seq_known_nxt  = seq_known_r;
    book_ready_nxt = book_ready_r;
    case (s1_func_r)
      obe_pkg::FUNC_CLEAR: begin
        wipe = 1'b1;
      end
      obe_pkg::FUNC_SNAP_BEGIN: begin
        wipe = 1'b1;
      end
      obe_pkg::FUNC_SNAP_LEVEL: begin
        if (price_ok) begin
          wr.en   = 1'b1;
          wr.set  = !s1_qty_r[QW-1] && (s1_qty_r != '0);
          wr.size = s1_qty_r[SW-1:0];
        end
      end
      obe_pkg::FUNC_DELTA: begin
        if (!seq_ok) begin
          wipe       = 1'b1;
          resync_nxt = 1'b1;
        end else if (price_ok) begin
          if (sum[SW+1]) begin
            wipe       = 1'b1;
            resync_nxt = 1'b1;
          end else begin
            wr.en        = 1'b1;
            wr.set       = (sum != '0);
            wr.size      = delta_size;
            last_seq_nxt = s1_seq_r;
          end
        end
      end
      default: begin
        wipe = 1'b1;
      end
    endcase
    if (wipe) begin
      last_seq_nxt   = '0;
      seq_known_nxt  = 1'b0;
      book_ready_nxt = 1'b0;
    end
    if (s1_func_r == obe_pkg::FUNC_SNAP_BEGIN) begin
      last_seq_nxt   = s1_seq_r;
      seq_known_nxt  = 1'b1;
      book_ready_nxt = 1'b1;
    end
  end

  always_comb begin
    wr_bid    = wr;
    wr_ask    = wr;
    wr_bid.en = wr.en && act && !s1_side_r;
    wr_ask.en = wr.en && act && s1_side_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_seq_r   <= '0;
      seq_known_r  <= 1'b0;
      book_ready_r <= 1'b0;
      fwd_v_r      <= 1'b0;
    end else if (adv) begin
      if (s1_v_r) begin
        last_seq_r   <= last_seq_nxt;
        seq_known_r  <= seq_known_nxt;
        book_ready_r <= book_ready_nxt;
      end
      fwd_v_r <= s1_v_r && wr.en && wr.set;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_side_r <= s1_side_r;
      fwd_idx_r  <= s1_price_r;
      fwd_size_r <= wr.size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_resync_r <= resync_nxt;
      s2_ready_r  <= book_ready_nxt;
    end
  end

  // ---- stage 2: top of book search ----
  logic          have_bid, have_ask, valid_nxt;
  logic [IW-1:0] top_bid, top_ask;

  always_comb begin
    have_bid  = |bid_present;
    have_ask  = |ask_present;
    top_bid   = have_bid ? obe_pkg::onehot_index(obe_pkg::highest_onehot(bid_present))
                         : '0;
    top_ask   = have_ask ? obe_pkg::onehot_index(obe_pkg::lowest_onehot(ask_present))
                         : TICK_IDX;
    valid_nxt = (top_bid != '0) && (top_ask < TICK_IDX) && (top_bid < top_ask);
  end

  obe_level_store u_bid (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .clear     (act && wipe),
    .wr        (wr_bid),
    .rd_a_idx  (in_tdata[6:0]),
    .rd_a_data (bid_rd_a),
    .rd_b_idx  (top_bid),
    .rd_b_data (bid_rd_b),
    .present   (bid_present)
  );

  obe_level_store u_ask (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .clear     (act && wipe),
    .wr        (wr_ask),
    .rd_a_idx  (in_tdata[6:0]),
    .rd_a_data (ask_rd_a),
    .rd_b_idx  (top_ask),
    .rd_b_data (ask_rd_b),
    .present   (ask_present)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_bid_r      <= top_bid;
      out_ask_r      <= top_ask;
      out_have_bid_r <= have_bid;
      out_have_ask_r <= have_ask;
      out_valid_r    <= valid_nxt;
      out_ready_r    <= s2_ready_r;
      out_resync_r   <= s2_resync_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_resync_r, out_ready_r, out_valid_r,
                       out_have_ask_r ? ask_rd_b : SW'(0),
                       out_have_bid_r ? bid_rd_b : SW'(0),
                       out_ask_r, out_bid_r};

endmodule

// ===== hdl/obe_checker.sv =====
// ----------------------------------------------------------------------------
// obe_checker
// Port-level checks on the order book level engine, bound to the top level.
// ----------------------------------------------------------------------------
module obe_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic [obe_pkg::IN_TUSER_W-1:0]     in_tuser,
  input logic [obe_pkg::IN_TDATA_W-1:0]     in_tdata,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic [obe_pkg::OUT_TDATA_W-1:0]    out_tdata,
  input logic                               out_tvalid,
  input logic                               out_tready
);

  localparam logic [obe_pkg::IDX_W-1:0] TICK_IDX = obe_pkg::IDX_W'(obe_pkg::TICK_COUNT);

  logic [obe_pkg::IDX_W-1:0]  bid, ask;
  logic [obe_pkg::SIZE_W-1:0] bsz, asz;
  logic                       bvalid, bready, rsync, in_seen;

  assign bid     = out_tdata[obe_pkg::OUT_ASK_LSB-1:obe_pkg::OUT_BID_LSB];
  assign ask     = out_tdata[obe_pkg::OUT_BSZ_LSB-1:obe_pkg::OUT_ASK_LSB];
  assign bsz     = out_tdata[obe_pkg::OUT_ASZ_LSB-1:obe_pkg::OUT_BSZ_LSB];
  assign asz     = out_tdata[obe_pkg::OUT_VALID_BIT-1:obe_pkg::OUT_ASZ_LSB];
  assign bvalid  = out_tdata[obe_pkg::OUT_VALID_BIT];
  assign bready  = out_tdata[obe_pkg::OUT_READY_BIT];
  assign rsync   = out_tdata[obe_pkg::OUT_RESYNC_BIT];
  assign in_seen = in_tvalid && in_tready && (in_tuser != '0 || in_tdata != '0);

  // a held result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // a resync leaves an empty, unready book
  a_resync_wipe: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rsync |-> !bready && !bvalid && bid == '0 && ask == TICK_IDX)
    else $error("resync result does not show a wiped book");

  a_valid_book: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && bvalid |-> bsz != '0 && asz != '0 && bid < ask)
    else $error("valid book with empty or crossed top");

  a_price_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid || in_seen |-> !out_tvalid || (bid <= TICK_IDX && ask <= TICK_IDX))
    else $error("best price beyond tick range");

endmodule

bind order_book_level_engine obe_checker u_obe_checker (.*);

// ===== test/order_book_level_engine_test.sv =====
// ----------------------------------------------------------------------------
// order_book_level_engine_test
// Self-checking bench for the price-level book. Book events are streamed in
// with random gaps while the result side stalls at random; an in-bench copy
// of the book predicts the top-of-book word for every accepted event, and
// each result word is compared field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module order_book_level_engine_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = obe_pkg::IDX_W;
  localparam int SW = obe_pkg::SIZE_W;
  localparam int QW = obe_pkg::QTY_W;
  localparam int DW = obe_pkg::SEQ_W;

  typedef struct packed {
    bit [IW-1:0] bid;
    bit [IW-1:0] ask;
    bit [SW-1:0] bid_sz;
    bit [SW-1:0] ask_sz;
    bit          valid;
    bit          rdy;
    bit          resync;
  } book_top_t;

  localparam bit SIDE_BID = 1'b0;
  localparam bit SIDE_ASK = 1'b1;

  logic                            clk;
  logic                            rst_n;
  logic [obe_pkg::IN_TUSER_W-1:0]  in_tuser;
  logic [obe_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [obe_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                            out_tvalid;
  logic                            out_tready;

  // in-bench book
  bit [SW-1:0] level_size [2][obe_pkg::LEVEL_DEPTH];
  bit          level_on   [2][obe_pkg::LEVEL_DEPTH];
  bit [DW-1:0] last_seq;
  bit          seq_known;
  bit          book_ready;

  book_top_t expected_tops[$];
  int        fault_count;
  bit        idle_on;
  int        hold_cycles;
  int        snap_left;

  order_book_level_engine i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("order_book_level_engine: mismatch");
    $finish;
  end

  function automatic void wipe_book_copy();
    for (int i = 0; i < obe_pkg::LEVEL_DEPTH; i++) begin
      level_on[0][i] = 1'b0;
      level_on[1][i] = 1'b0;
    end
    last_seq   = '0;
    seq_known  = 1'b0;
    book_ready = 1'b0;
  endfunction

  // apply one event to the book copy and work out the top-of-book word
  function automatic book_top_t update_book(obe_pkg::func_t f, bit s, bit [IW-1:0] p,
                                            bit [QW-1:0] q, bit [DW-1:0] sq);
    book_top_t top;
    bit        hit_resync;
    longint    upd;
    hit_resync = 1'b0;
    case (f)
      obe_pkg::FUNC_CLEAR: wipe_book_copy();
      obe_pkg::FUNC_SNAP_BEGIN: begin
        wipe_book_copy();
        last_seq   = sq;
        seq_known  = 1'b1;
        book_ready = 1'b1;
      end
      obe_pkg::FUNC_SNAP_LEVEL: begin
        if (p <= obe_pkg::TICK_COUNT) begin
          if ($signed(q) <= 0) begin
            level_on[s][p] = 1'b0;
          end else begin
            level_size[s][p] = q[SW-1:0];
            level_on[s][p]   = 1'b1;
          end
        end
      end
      default: begin
        if (!seq_known || sq != last_seq + 32'd1) begin
          wipe_book_copy();
          hit_resync = 1'b1;
        end else if (p <= obe_pkg::TICK_COUNT) begin
          upd = longint'($signed(q));
          if (level_on[s][p]) upd += longint'(level_size[s][p]);
          if (upd < 0) begin
            wipe_book_copy();
            hit_resync = 1'b1;
          end else begin
            if (upd == 0) begin
              level_on[s][p] = 1'b0;
            end else begin
              if (upd > longint'(obe_pkg::SIZE_MAX)) upd = longint'(obe_pkg::SIZE_MAX);
              level_size[s][p] = upd[SW-1:0];
              level_on[s][p]   = 1'b1;
            end
            last_seq = sq;
          end
        end
      end
    endcase

    top     = '0;
    top.ask = IW'(obe_pkg::TICK_COUNT);
    for (int i = obe_pkg::TICK_COUNT; i >= 0; i--) begin
      if (level_on[0][i]) begin
        top.bid    = IW'(i);
        top.bid_sz = level_size[0][i];
        break;
      end
    end
    for (int i = 0; i <= obe_pkg::TICK_COUNT; i++) begin
      if (level_on[1][i]) begin
        top.ask    = IW'(i);
        top.ask_sz = level_size[1][i];
        break;
      end
    end
    top.valid  = top.bid > 0 && top.ask < obe_pkg::TICK_COUNT && top.bid < top.ask;
    top.rdy    = book_ready;
    top.resync = hit_resync;
    return top;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(obe_pkg::func_t f, bit s, bit [IW-1:0] p, bit [QW-1:0] q,
                           bit [DW-1:0] sq);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {s, f};
    in_tdata  <= {1'b0, sq, q, p};
    do @(posedge clk); while (!in_tready);
    expected_tops.push_back(update_book(f, s, p, q, sq));
  endtask

  // sender stays quiet until every predicted word has come back
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_tops.size() != 0);
  endtask

  function automatic bit [IW-1:0] pick_price(bit s);
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return IW'($urandom_range(obe_pkg::TICK_COUNT + 1, obe_pkg::LEVEL_DEPTH - 1));
    if (r < 15) return IW'($urandom_range(0, obe_pkg::TICK_COUNT));
    return (s == SIDE_BID) ? IW'($urandom_range(20, 55)) : IW'($urandom_range(45, 80));
  endfunction

  // delta size partly chosen against the current level so the book lives on
  function automatic bit [QW-1:0] pick_delta_qty(bit s, bit [IW-1:0] p);
    longint cur;
    int     r;
    cur = (p <= obe_pkg::TICK_COUNT && level_on[s][p]) ? longint'(level_size[s][p]) : 0;
    r   = $urandom_range(0, 99);
    if (r < 45) return QW'($urandom_range(1, 5000));
    if (r < 70 && cur > 0) return QW'(-longint'($urandom_range(1, 32'(cur))));
    if (r < 80) return QW'(-cur);
    if (r < 88) return $urandom;
    if (r < 92) return QW'(-(cur + 1));
    return QW'($urandom_range(32'h7FFF_0000, 32'h7FFF_FFFF));
  endfunction

  // one event of a feed: snapshot, its levels, then in-order deltas,
  // salted with gaps, clears and stray prices
  task automatic feed_event();
    bit          s;
    bit [IW-1:0] p;
    bit [QW-1:0] q;
    bit [DW-1:0] sq;
    int          r;
    s = 1'($urandom_range(0, 1));
    p = pick_price(s);
    r = $urandom_range(0, 99);
    if (!seq_known && r < 85 || seq_known && snap_left == 0 && r < 2) begin
      sq        = ($urandom_range(0, 4) == 0) ? $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF)
                                              : $urandom;
      snap_left = $urandom_range(2, 12);
      send_word(obe_pkg::FUNC_SNAP_BEGIN, s, IW'($urandom), $urandom, sq);
    end else if (seq_known && snap_left > 0 || r >= 97) begin
      r = $urandom_range(0, 9);
      if (r < 8) q = $urandom_range(1, 100000);
      else if (r < 9) q = -$urandom_range(0, 1000);
      else q = $urandom;
      if (snap_left > 0) snap_left--;
      send_word(obe_pkg::FUNC_SNAP_LEVEL, s, p, q, $urandom);
    end else if (r < 4) begin
      send_word(obe_pkg::FUNC_CLEAR, s, p, $urandom, $urandom);
    end else begin
      sq = last_seq + 32'd1;
      if ($urandom_range(0, 99) < 3) sq = sq + $urandom_range(1, 40);
      else if ($urandom_range(0, 99) < 2) sq = $urandom;
      send_word(obe_pkg::FUNC_DELTA, s, p, pick_delta_qty(s, p), sq);
    end
  endtask

  task automatic test_directed_cases();
    idle_on = 1'b1;
    // levels land before any snapshot; a delta with no sequence resyncs
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_BID, 7'd10, 32'd500, $urandom);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_ASK, 7'd90, 32'd7, $urandom);
    send_word(obe_pkg::FUNC_DELTA, SIDE_BID, 7'd10, 32'd1, 32'd1);
    send_word(obe_pkg::FUNC_SNAP_BEGIN, 1'($urandom), IW'($urandom), $urandom,
              32'hFFFF_FFFE);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_BID, 7'd0, 32'd1, $urandom);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_ASK, 7'd100, 32'h7FFF_FFFF, $urandom);
    // prices beyond the tick count are dropped
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_BID, 7'd101, 32'd9, $urandom);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_ASK, 7'd127, 32'd9, $urandom);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_BID, 7'd40, 32'd300, $urandom);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_ASK, 7'd60, 32'd200, $urandom);
    // sequence wraps through zero; size saturates
    send_word(obe_pkg::FUNC_DELTA, SIDE_BID, 7'd40, 32'd5, 32'hFFFF_FFFF);
    send_word(obe_pkg::FUNC_DELTA, SIDE_BID, 7'd40, 32'h7FFF_FFFF, 32'd0);
    // stray price with a good sequence: sequence must not advance
    send_word(obe_pkg::FUNC_DELTA, SIDE_ASK, 7'd120, 32'd50, 32'd1);
    send_word(obe_pkg::FUNC_DELTA, SIDE_ASK, 7'd60, -32'sd200, 32'd1);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_ASK, 7'd100, 32'd0, $urandom);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_BID, 7'd70, 32'h8000_0000, $urandom);
    // crossed book
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_ASK, 7'd30, 32'd10, $urandom);
    // level driven below zero
    send_word(obe_pkg::FUNC_DELTA, SIDE_BID, 7'd40, 32'h8000_0000, 32'd2);
    send_word(obe_pkg::FUNC_SNAP_BEGIN, 1'($urandom), IW'($urandom), $urandom, 32'd500);
    send_word(obe_pkg::FUNC_DELTA, SIDE_BID, 7'd20, 32'd100, 32'd501);
    send_word(obe_pkg::FUNC_DELTA, SIDE_BID, 7'd20, 32'd5, 32'd503);
    send_word(obe_pkg::FUNC_SNAP_BEGIN, 1'($urandom), IW'($urandom), $urandom, 32'd7);
    send_word(obe_pkg::FUNC_SNAP_LEVEL, SIDE_BID, 7'd50, 32'd9, $urandom);
    send_word(obe_pkg::FUNC_CLEAR, 1'($urandom), IW'($urandom), $urandom, $urandom);
    send_word(obe_pkg::FUNC_DELTA, SIDE_ASK, 7'd50, 32'd1, 32'd8);
    wait_drained();
  endtask

  task automatic test_random_feed();
    idle_on = 1'b1;
    repeat (900) feed_event();
    wait_drained();
  endtask

  // result side held off for a long stretch while words keep coming
  task automatic test_backpressure();
    idle_on     = 1'b0;
    hold_cycles = 300;
    repeat (60) feed_event();
    wait_drained();
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (150) feed_event();
    wait_drained();
  endtask

  // result side: random ready runs and stalls, or a requested hold-off
  initial begin
    int rx_left;
    bit rx_ready;
    rx_left    = 0;
    rx_ready   = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        rx_left     = hold_cycles;
        hold_cycles = 0;
        rx_ready    = 1'b0;
      end else if (rx_left > 0) begin
        rx_left--;
      end else if (!idle_on || !rx_ready) begin
        rx_ready = 1'b1;
        rx_left  = $urandom_range(0, 20);
      end else begin
        rx_ready = 1'b0;
        rx_left  = pick_gap();
      end
      out_tready <= rx_ready;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    book_top_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_tops.size() == 0) begin
        $error("result word with nothing outstanding: 0x%0h", out_tdata);
        fault_count++;
      end else begin
        want = expected_tops.pop_front();
        check_field("top_bid", 64'(want.bid),
                    64'(out_tdata[obe_pkg::OUT_BID_LSB +: IW]));
        check_field("top_ask", 64'(want.ask),
                    64'(out_tdata[obe_pkg::OUT_ASK_LSB +: IW]));
        check_field("top_bid_qty", 64'(want.bid_sz),
                    64'(out_tdata[obe_pkg::OUT_BSZ_LSB +: SW]));
        check_field("top_ask_qty", 64'(want.ask_sz),
                    64'(out_tdata[obe_pkg::OUT_ASZ_LSB +: SW]));
        check_field("book_valid", 64'(want.valid),
                    64'(out_tdata[obe_pkg::OUT_VALID_BIT]));
        check_field("ready_res", 64'(want.rdy),
                    64'(out_tdata[obe_pkg::OUT_READY_BIT]));
        check_field("resync", 64'(want.resync),
                    64'(out_tdata[obe_pkg::OUT_RESYNC_BIT]));
      end
    end
  end

  initial begin
    fault_count = 0;
    idle_on     = 1'b1;
    hold_cycles = 0;
    snap_left   = 0;
    for (int i = 0; i < obe_pkg::LEVEL_DEPTH; i++) begin
      level_size[0][i] = '0;
      level_size[1][i] = '0;
    end
    wipe_book_copy();
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser  <= '0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_feed();
    test_backpressure();
    test_full_rate();

    repeat (10) @(posedge clk);
    if (fault_count == 0 && expected_tops.size() == 0) begin
      $display("order_book_level_engine: match");
    end else begin
      $display("order_book_level_engine: mismatch");
    end
    $finish;
  end

endmodule

// ===== order_book_level_engine.f =====
hdl/obe_pkg.sv
hdl/obe_level_store.sv
hdl/order_book_level_engine.sv
hdl/obe_checker.sv
test/order_book_level_engine_test.sv
